[src/bvhd_pkg.sv]
// ---------------------------------------------------------------------------
// bvhd_pkg: shared types and constants for the byte vector Hamming distance
// Widths of the byte lanes, the running total and the single-precision result.
// ---------------------------------------------------------------------------
package bvhd_pkg;

  // Byte lanes that one input word carries.
  localparam int ITEM_LANES = 8;
  localparam int BYTE_W     = 8;
  // Bit count of one byte lane, 0 to 8.
  localparam int LANE_CNT_W = 4;
  // Running total and float widths.
  localparam int TOTAL_W    = 36;
  localparam int FLOAT_W    = 32;
  localparam int BCNT_W     = 4;
  // Leading-one search works on groups of six bits.
  localparam int GROUP_W    = 6;
  localparam int N_GROUPS   = TOTAL_W / GROUP_W;
  localparam int GPOS_W     = 3;
  localparam int GIDX_W     = 3;
  localparam int MSB_W      = 6;
  localparam int EXP_W      = 8;
  localparam int MANT_W     = 24;
  localparam int EXP_BIAS   = 127;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [LANE_CNT_W-1:0] lane_cnt_t;
  typedef logic [TOTAL_W-1:0]    count_t;
  typedef logic [FLOAT_W-1:0]    float_t;
  typedef logic [BCNT_W-1:0]     bcnt_t;

endpackage

[src/byte_vector_hamming_distance.sv]
// ---------------------------------------------------------------------------
// byte_vector_hamming_distance: bitwise Hamming distance of byte vectors
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_stall, a_bytes, b_bytes,     | in
//           | byte_count, is_last                       |
//   output  | out_valid, out_stall, distance_count,     | out
//           | distance_float                            |
//
// One input word is taken per cycle unless stalled. A last word's result
// passes the lane popcount register, merge and accumulate register, then
// the three-stage float conversion. Reset clears the running total and all
// valid flags. Output stall holds the result register and backs up through
// the stages; words without last are always absorbed by the accumulator.
// ---------------------------------------------------------------------------
module byte_vector_hamming_distance #(
  parameter int LANES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [63:0]                 a_bytes,
  input  logic [63:0]                 b_bytes,
  input  bvhd_pkg::bcnt_t             byte_count,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bvhd_pkg::count_t            distance_count,
  output bvhd_pkg::float_t            distance_float
);
  import bvhd_pkg::*;

  localparam int NL = (LANES < ITEM_LANES) ? LANES : ITEM_LANES;

  lane_cnt_t  cnt_c  [NL];
  lane_cnt_t  s1_cnt [NL];
  logic       s1_valid;
  logic       s1_last;
  logic       m_ready;
  logic       s1_load;
  logic       res_valid;
  count_t     res_count;
  logic       f_ready;

  // Lanes working side by side on the bytes of one word.
  for (genvar i = 0; i < NL; i++) begin : g_lane
    bvhd_lane u_lane (
      .a_byte  (a_bytes[i*BYTE_W +: BYTE_W]),
      .b_byte  (b_bytes[i*BYTE_W +: BYTE_W]),
      .lane_en (bcnt_t'(i) < byte_count),
      .cnt     (cnt_c[i])
    );
  end

  // Lane count register.
  assign in_stall = s1_valid && !m_ready;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last <= is_last;
      s1_cnt  <= cnt_c;
    end
  end

  // Merge the lanes into the running total.
  bvhd_merge #(
    .NLANES (NL)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (s1_valid),
    .lane_last  (s1_last),
    .lane_cnt   (s1_cnt),
    .lane_ready (m_ready),
    .res_valid  (res_valid),
    .res_count  (res_count),
    .res_ready  (f_ready)
  );

  // Float conversion and output register.
  bvhd_float u_float (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_count  (res_count),
    .in_ready  (f_ready),
    .out_valid (out_valid),
    .out_count (distance_count),
    .out_float (distance_float),
    .out_ready (!out_stall)
  );

endmodule

[src/bvhd_lane.sv]
// ---------------------------------------------------------------------------
// bvhd_lane: one byte lane of the distance datapath
// XORs a byte pair and counts the differing bits when the lane is enabled.
// ---------------------------------------------------------------------------
module bvhd_lane (
  input  bvhd_pkg::byte_t     a_byte,
  input  bvhd_pkg::byte_t     b_byte,
  input  logic                lane_en,
  output bvhd_pkg::lane_cnt_t cnt
);
  import bvhd_pkg::*;

  byte_t diff;

  // Differing bits of the pair; a disabled lane counts nothing.
  assign diff = lane_en ? (a_byte ^ b_byte) : '0;

  // Population count of the eight difference bits.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      cnt = cnt + lane_cnt_t'(diff[i]);
    end
  end

endmodule

[src/bvhd_merge.sv]
// ---------------------------------------------------------------------------
// bvhd_merge: merges the lane counts into the running total
// Sums the lane counts, adds them to the saturating total and, on the last
// word of a vector, hands the total on and clears it.
// ---------------------------------------------------------------------------
module bvhd_merge #(
  parameter int NLANES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                lane_valid,
  input  logic                lane_last,
  input  bvhd_pkg::lane_cnt_t lane_cnt [NLANES],
  output logic                lane_ready,
  output logic                res_valid,
  output bvhd_pkg::count_t    res_count,
  input  logic                res_ready
);
  import bvhd_pkg::*;

  localparam int SUM_W = $clog2(NLANES * BYTE_W + 1);

  logic [SUM_W-1:0]   lane_sum;
  logic [TOTAL_W:0]   total_add;
  count_t             total_next;
  count_t             running_total;
  logic               take;

  // A word that is not last never waits; a last word needs the result slot.
  assign lane_ready = !lane_last || !res_valid || res_ready;
  assign take       = lane_valid && lane_ready;

  // Merge the lane counts.
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < NLANES; i++) begin
      lane_sum = lane_sum + SUM_W'(lane_cnt[i]);
    end
  end

  // Saturating accumulate.
  assign total_add  = {1'b0, running_total} + (TOTAL_W + 1)'(lane_sum);
  assign total_next = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];

  // Running total and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (take && lane_last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        running_total <= lane_last ? '0 : total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && lane_last) begin
      res_count <= total_next;
    end
  end

endmodule

[src/bvhd_float.sv]
// ---------------------------------------------------------------------------
// bvhd_float: integer to single-precision conversion pipeline
// Three stages: group leading-one search, normalising shift, then rounding
// to nearest even and packing. The integer count travels alongside.
// ---------------------------------------------------------------------------
module bvhd_float (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  bvhd_pkg::count_t in_count,
  output logic             in_ready,
  output logic             out_valid,
  output bvhd_pkg::count_t out_count,
  output bvhd_pkg::float_t out_float,
  input  logic             out_ready
);
  import bvhd_pkg::*;

  // Stage one registers.
  logic                     v1;
  count_t                   c1;
  logic [N_GROUPS-1:0]      g1_nz;
  logic [GPOS_W-1:0]        g1_pos [N_GROUPS];
  // Stage two registers.
  logic                     v2;
  count_t                   c2;
  count_t                   norm2;
  logic [MSB_W-1:0]         msb2;
  logic                     nz2;
  // Stage three registers are the outputs.
  logic                     v3;

  logic                     rdy1, rdy2, rdy3;
  logic [GPOS_W-1:0]        pos_c [N_GROUPS];
  logic [N_GROUPS-1:0]      nz_c;
  logic [GIDX_W-1:0]        grp_c;
  logic [MSB_W-1:0]         msb_c;
  logic [MSB_W-1:0]         shift_c;
  logic [MANT_W-1:0]        mant_c;
  logic                     guard_c, sticky_c, round_c;
  logic [MANT_W:0]          mant_r;
  logic [EXP_W-1:0]         exp_c;
  float_t                   float_c;

  // Each stage loads when it is empty or its word moves on.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // Leading one inside each six-bit group.
  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      pos_c[g] = '0;
      nz_c[g]  = |in_count[g*GROUP_W +: GROUP_W];
      for (int b = 0; b < GROUP_W; b++) begin
        if (in_count[g*GROUP_W + b]) begin
          pos_c[g] = GPOS_W'(b);
        end
      end
    end
  end

  // Highest non-empty group gives the leading-one position.
  always_comb begin
    grp_c = '0;
    for (int g = 0; g < N_GROUPS; g++) begin
      if (g1_nz[g]) begin
        grp_c = GIDX_W'(g);
      end
    end
    msb_c   = MSB_W'(grp_c) * MSB_W'(GROUP_W) + MSB_W'(g1_pos[grp_c]);
    shift_c = MSB_W'(TOTAL_W - 1) - msb_c;
  end

  // Round to nearest even on the normalised value and pack.
  always_comb begin
    mant_c   = norm2[TOTAL_W-1 -: MANT_W];
    guard_c  = norm2[TOTAL_W-1-MANT_W];
    sticky_c = |norm2[TOTAL_W-2-MANT_W:0];
    round_c  = guard_c && (sticky_c || mant_c[0]);
    mant_r   = {1'b0, mant_c} + (MANT_W + 1)'(round_c);
    exp_c    = EXP_W'(msb2) + EXP_W'(EXP_BIAS) + EXP_W'(mant_r[MANT_W]);
    if (!nz2) begin
      float_c = '0;
    end else if (mant_r[MANT_W]) begin
      float_c = {1'b0, exp_c, (MANT_W - 1)'(0)};
    end else begin
      float_c = {1'b0, exp_c, mant_r[MANT_W-2:0]};
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      c1     <= in_count;
      g1_nz  <= nz_c;
      g1_pos <= pos_c;
    end
    if (rdy2 && v1) begin
      c2    <= c1;
      norm2 <= c1 << shift_c;
      msb2  <= msb_c;
      nz2   <= |g1_nz;
    end
    if (rdy3 && v2) begin
      out_count <= c2;
      out_float <= float_c;
    end
  end

endmodule
